// ===== sv/taq_pkg.sv =====
// Shared types and constants for the time-ordered action queue.
// Holds the stored entry layout, the emit handoff and the operation codes.
// Has no dependencies.
package taq_pkg;

    localparam int TIME_W = 48;
    localparam int KIND_W = 8;
    localparam int VAL_W  = 64;
    localparam int SINT_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]        due_time;
        logic [KIND_W-1:0]        kind;
        logic [VAL_W-1:0]         value_a;
        logic [VAL_W-1:0]         value_b;
        logic signed [SINT_W-1:0] small_int;
        logic                     flag;
    } t_entry;

    typedef struct packed {
        logic   valid;
        logic   last;
        t_entry entry;
    } t_emit;

endpackage

// ===== sv/taq_if.sv =====
// Handshake interfaces for the time-ordered action queue channels.
// taq_in_if carries request words and taq_out_if carries released actions.
// Depends on taq_pkg for field widths.
interface taq_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      operation;
    logic [taq_pkg::TIME_W-1:0]                time_req;
    logic [taq_pkg::KIND_W-1:0]                action_kind;
    logic [taq_pkg::VAL_W-1:0]                 value_a;
    logic [taq_pkg::VAL_W-1:0]                 value_b;
    logic signed [taq_pkg::SINT_W-1:0]         small_int;
    logic                                      flag;

    modport source (
        output valid, operation, time_req, action_kind, value_a, value_b, small_int, flag,
        input  ready
    );
    modport sink (
        input  valid, operation, time_req, action_kind, value_a, value_b, small_int, flag,
        output ready
    );
endinterface

interface taq_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [taq_pkg::TIME_W-1:0]                due_time;
    logic [taq_pkg::KIND_W-1:0]                out_kind;
    logic [taq_pkg::VAL_W-1:0]                 out_value_a;
    logic [taq_pkg::VAL_W-1:0]                 out_value_b;
    logic signed [taq_pkg::SINT_W-1:0]         out_small_int;
    logic                                      out_flag;
    logic                                      last;

    modport source (
        output valid, due_time, out_kind, out_value_a, out_value_b, out_small_int,
               out_flag, last,
        input  ready
    );
    modport sink (
        input  valid, due_time, out_kind, out_value_a, out_value_b, out_small_int,
               out_flag, last,
        output ready
    );
endinterface

// ===== sv/time_ordered_action_queue.sv =====
// Time-ordered action queue: a bounded list of timed actions sorted by due time.
// A schedule word moves each stored entry due later than it up one place and stops at the
// head or at the first entry that is not later. A tick word releases the due actions in
// order from the head; its pace is set by the registered memory read and the shared time
// comparator, and output stalls hold it.
// Reset (synchronous) empties the queue and sets capacity to 16; memory is not cleared.
module time_ordered_action_queue #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [taq_pkg::CAP_W-1:0]   i_cfg_wdata,
    taq_in_if.sink                      i_in,
    taq_out_if.source                   o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [taq_pkg::CAP_W-1:0] r_cap;
    logic                      r_out_valid;
    logic                      r_out_last;
    taq_pkg::t_entry           r_out;

    logic                      w_idle;
    logic                      w_accept;
    logic                      w_out_free;
    taq_pkg::t_entry           w_in_entry;
    taq_pkg::t_entry           w_rd_data;
    taq_pkg::t_entry           w_wdata;
    taq_pkg::t_emit            w_emit;
    logic                      w_we;
    logic                      w_re;
    logic [AW-1:0]             w_waddr;
    logic [AW-1:0]             w_raddr;

    assign i_in.ready = w_idle;
    assign w_accept   = i_in.valid && w_idle;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_in_entry.due_time  = i_in.time_req;
    assign w_in_entry.kind      = i_in.action_kind;
    assign w_in_entry.value_a   = i_in.value_a;
    assign w_in_entry.value_b   = i_in.value_b;
    assign w_in_entry.small_int = i_in.small_int;
    assign w_in_entry.flag      = i_in.flag;

    taq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    taq_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (i_in.operation),
        .i_entry    (w_in_entry),
        .i_cap      (r_cap),
        .i_out_free (w_out_free),
        .i_rd_data  (w_rd_data),
        .o_idle     (w_idle),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .o_emit     (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= taq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_emit.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_out      <= w_emit.entry;
            r_out_last <= w_emit.last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.due_time      = r_out.due_time;
    assign o_out.out_kind      = r_out.kind;
    assign o_out.out_value_a   = r_out.value_a;
    assign o_out.out_value_b   = r_out.value_b;
    assign o_out.out_small_int = r_out.small_int;
    assign o_out.out_flag      = r_out.flag;
    assign o_out.last          = r_out_last;

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.valid |-> w_out_free)
        else $error("Released word overwrote an unread output word.");

    a_schedule_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == taq_pkg::OP_SCHEDULE) |=> !w_emit.valid)
        else $error("A schedule word released an action.");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit.valid && w_emit.last) |=> (w_idle && !w_emit.valid))
        else $error("Tick continued after its last released word.");

endmodule

// ===== sv/taq_store.sv =====
// Entry memory of the action queue: one write port and one registered read port.
// Depends on taq_pkg for the entry layout.
module taq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  taq_pkg::t_entry     i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output taq_pkg::t_entry     o_rdata
);

    taq_pkg::t_entry r_mem [DEPTH];
    taq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

// ===== sv/taq_seq.sv =====
// Sequencer of the action queue: sorted insert and due release over a ring buffer.
// One shared time comparator serves both operations, one entry at a time.
// Depends on taq_pkg; drives the taq_store ports.
module taq_seq #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_op,
    input  taq_pkg::t_entry             i_entry,
    input  logic [taq_pkg::CAP_W-1:0]   i_cap,
    input  logic                        i_out_free,
    input  taq_pkg::t_entry             i_rd_data,
    output logic                        o_idle,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output taq_pkg::t_entry             o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    output taq_pkg::t_emit              o_emit
);

    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_TK_RD   = 3'd3;
    localparam logic [2:0] S_TK_CMP  = 3'd4;
    localparam logic [2:0] S_TK_LAST = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_pos, n_pos;
    taq_pkg::t_entry r_new, n_new;
    logic            r_pend_valid, n_pend_valid;
    taq_pkg::t_entry r_pend, n_pend;

    logic [CW-1:0]   cap_eff;
    logic [SW-1:0]   cnt_inc;
    logic [CW-1:0]   cnt_sat;
    logic            time_le;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        if (int'(i_cap) > DEPTH) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(i_cap);
        end
        cnt_inc = SW'(r_count) + SW'(1);
        cnt_sat = (cnt_inc > SW'(cap_eff)) ? cap_eff : cnt_inc[CW-1:0];
        time_le = i_rd_data.due_time <= r_new.due_time;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_pos        = r_pos;
        n_new        = r_new;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_we         = 1'b0;
        o_waddr      = f_phys(r_head, r_pos);
        o_wdata      = r_new;
        o_re         = 1'b0;
        o_raddr      = f_phys(r_head, r_pos - CW'(1));
        o_emit.valid = 1'b0;
        o_emit.last  = 1'b0;
        o_emit.entry = r_pend;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_new = i_entry;
                    n_pos = r_count;
                    n_pend_valid = 1'b0;
                    n_state = (i_op == taq_pkg::OP_SCHEDULE) ? S_INS_RD : S_TK_RD;
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    o_we    = cap_eff != '0;
                    n_count = cnt_sat;
                    n_state = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_we = r_pos < cap_eff;
                if (!time_le) begin
                    o_wdata = i_rd_data;
                    n_pos   = r_pos - CW'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_count = cnt_sat;
                    n_state = S_IDLE;
                end
            end
            S_TK_RD: begin
                o_raddr = r_head;
                if (r_count == '0) begin
                    n_state = r_pend_valid ? S_TK_LAST : S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    n_state = S_TK_CMP;
                end
            end
            S_TK_CMP: begin
                if (time_le) begin
                    if (!r_pend_valid || i_out_free) begin
                        o_emit.valid = r_pend_valid;
                        n_pend       = i_rd_data;
                        n_pend_valid = 1'b1;
                        n_head       = f_phys(r_head, CW'(1));
                        n_count      = r_count - CW'(1);
                        n_state      = S_TK_RD;
                    end
                end else begin
                    n_state = r_pend_valid ? S_TK_LAST : S_IDLE;
                end
            end
            S_TK_LAST: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_new  <= n_new;
        r_pend <= n_pend;
    end

    assign o_idle = r_state == S_IDLE;

endmodule
